@@ hdl/pad_pkg.sv @@
// ---------------------------------------------------------------------------
// pad_pkg
// Types, widths and tables shared by the point angle / distance unit.
// ---------------------------------------------------------------------------
package pad_pkg;

	localparam int COORD_W      = 24;
	localparam int FRAC_W       = 8;
	localparam int UPM_W        = 20;
	localparam logic [UPM_W-1:0] UPM_RESET = 20'd10000;
	localparam int DIST_W       = COORD_W + 1 + FRAC_W;  // 33
	localparam int ANGLE_W      = 9 + FRAC_W;            // 17

	// distance path
	localparam int SUM_W        = 2 * COORD_W + 1;       // dx^2 + dy^2
	localparam int SQ_STEPS     = DIST_W;                // one root bit per cell
	localparam int RAD_W        = 2 * SQ_STEPS;
	localparam int REM_W        = DIST_W + 2;
	localparam int DIV_STEPS    = DIST_W;

	// angle path
	localparam int CORDIC_STEPS = 20;
	localparam int GUARD_SHIFT  = 55 - COORD_W;
	localparam int XW           = 58;
	localparam logic [ANGLE_W-1:0] FULL_TURN = 17'd92160;  // 360 << FRAC_W

	// pipeline stage numbers
	localparam int LAT       = 3 + SQ_STEPS + DIV_STEPS;  // last divider cell
	localparam int ANG_STAGE = 2 + CORDIC_STEPS + 2;
	localparam int ANG_DLY   = LAT - ANG_STAGE;

	typedef struct packed {
		logic                       mode;
		logic signed [COORD_W-1:0]  first_x;
		logic signed [COORD_W-1:0]  first_y;
		logic signed [COORD_W-1:0]  middle_x;
		logic signed [COORD_W-1:0]  middle_y;
		logic signed [COORD_W-1:0]  last_x;
		logic signed [COORD_W-1:0]  last_y;
	} pad_in_t;

	typedef struct packed {
		logic [DIST_W-1:0]  distance_mm;
		logic [ANGLE_W-1:0] angle_deg;
		logic               zero_length;
	} pad_out_t;

	typedef struct packed {
		logic [RAD_W-1:0]  rad;
		logic [REM_W-1:0]  rem;
		logic [DIST_W-1:0] root;
	} pad_sq_t;

	typedef struct packed {
		logic [DIST_W-1:0] num;
		logic [UPM_W-1:0]  rem;
		logic [DIST_W-1:0] quot;
	} pad_dv_t;

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic [31:0]          z;
	} pad_cr_t;

	// atan(2^-k) in binary angle units, 2^32 = one turn
	function automatic logic [31:0] atan_bam(input logic [4:0] k);
		logic [31:0] r;
		case (k)
			5'd0:  r = 32'h20000000;
			5'd1:  r = 32'h12E4051E;
			5'd2:  r = 32'h09FB385B;
			5'd3:  r = 32'h051111D4;
			5'd4:  r = 32'h028B0D43;
			5'd5:  r = 32'h0145D7E1;
			5'd6:  r = 32'h00A2F61E;
			5'd7:  r = 32'h00517C55;
			5'd8:  r = 32'h0028BE53;
			5'd9:  r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2FA;
			5'd15: r = 32'h0000517D;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A30;
			5'd19: r = 32'h00000518;
			5'd20: r = 32'h0000028C;
			5'd21: r = 32'h00000146;
			5'd22: r = 32'h000000A3;
			5'd23: r = 32'h00000051;
			5'd24: r = 32'h00000029;
			5'd25: r = 32'h00000014;
			5'd26: r = 32'h0000000A;
			5'd27: r = 32'h00000005;
			5'd28: r = 32'h00000003;
			5'd29: r = 32'h00000001;
			5'd30: r = 32'h00000001;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

endpackage

@@ hdl/pad_sqrt_cell.sv @@
// ---------------------------------------------------------------------------
// pad_sqrt_cell
// One digit-by-digit square root step: brings down two radicand bits.
// ---------------------------------------------------------------------------
module pad_sqrt_cell (
	input  logic             clk,
	input  logic             en,
	input  pad_pkg::pad_sq_t d,
	output pad_pkg::pad_sq_t q
);
	import pad_pkg::*;

	logic [REM_W+1:0] remx;
	logic [REM_W+1:0] trial;

	assign remx  = {d.rem, d.rad[RAD_W-1 -: 2]};
	assign trial = {2'b00, d.root, 2'b01};

	always_ff @(posedge clk) begin
		if (en) begin
			q.rad <= {d.rad[RAD_W-3:0], 2'b00};
			if (remx >= trial) begin
				q.rem  <= REM_W'(remx - trial);
				q.root <= {d.root[DIST_W-2:0], 1'b1};
			end else begin
				q.rem  <= REM_W'(remx);
				q.root <= {d.root[DIST_W-2:0], 1'b0};
			end
		end
	end

endmodule

@@ hdl/pad_div_cell.sv @@
// ---------------------------------------------------------------------------
// pad_div_cell
// One restoring division step: one quotient bit per cell.
// ---------------------------------------------------------------------------
module pad_div_cell (
	input  logic                       clk,
	input  logic                       en,
	input  logic [pad_pkg::UPM_W-1:0]  divisor,
	input  pad_pkg::pad_dv_t           d,
	output pad_pkg::pad_dv_t           q
);
	import pad_pkg::*;

	logic [UPM_W:0] remx;

	assign remx = {d.rem, d.num[DIST_W-1]};

	always_ff @(posedge clk) begin
		if (en) begin
			q.num <= {d.num[DIST_W-2:0], 1'b0};
			if (remx >= {1'b0, divisor}) begin
				q.rem  <= UPM_W'(remx - {1'b0, divisor});
				q.quot <= {d.quot[DIST_W-2:0], 1'b1};
			end else begin
				q.rem  <= UPM_W'(remx);
				q.quot <= {d.quot[DIST_W-2:0], 1'b0};
			end
		end
	end

endmodule

@@ hdl/pad_cordic_cell.sv @@
// ---------------------------------------------------------------------------
// pad_cordic_cell
// One CORDIC vectoring iteration, driving y toward zero.
// ---------------------------------------------------------------------------
module pad_cordic_cell (
	input  logic             clk,
	input  logic             en,
	input  logic [4:0]       k,
	input  pad_pkg::pad_cr_t d,
	output pad_pkg::pad_cr_t q
);
	import pad_pkg::*;

	logic signed [XW-1:0] xs;
	logic signed [XW-1:0] ys;

	assign xs = d.x >>> k;
	assign ys = d.y >>> k;

	always_ff @(posedge clk) begin
		if (en) begin
			if (!d.y[XW-1]) begin
				q.x <= d.x + ys;
				q.y <= d.y - xs;
				q.z <= d.z + atan_bam(k);
			end else begin
				q.x <= d.x - ys;
				q.y <= d.y + xs;
				q.z <= d.z - atan_bam(k);
			end
		end
	end

endmodule

@@ hdl/point_angle_distance_unit_core.sv @@
// ---------------------------------------------------------------------------
// point_angle_distance_unit_core
// Distance between two points or angle at a vertex, fully pipelined.
// ---------------------------------------------------------------------------
// Usage:
//   pt/pt_valid/pt_stall carries one point triple plus mode per transaction.
//   res/res_valid/res_stall returns one result per transaction, in order.
//   Mode 0: distance first->middle in mm (8 fraction bits, truncated).
//   Mode 1: angle at middle from first ray to last ray, degrees [0,360),
//   8 fraction bits; a zero-length ray gives 0 with zero_length set.
//   cfg_we/cfg_wdata writes units_per_mm (0 acts as 1); write while idle.
// Timing:
//   70 register stages, set by the distance path: 3 setup stages, 33 square
//   root cells, 33 divider cells, output. The angle path (20 CORDIC cells
//   per ray) is delayed to match. Throughput is one transaction per cycle
//   while the pipeline is not held by res_stall.
// Reset clears all valid bits and loads units_per_mm with 10000.
// While res_valid is high and res_stall is high the whole pipeline holds,
// and pt_stall is raised; no result is lost.
// ---------------------------------------------------------------------------
module point_angle_distance_unit_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [pad_pkg::UPM_W-1:0] cfg_wdata,
	input  logic                      pt_valid,
	output logic                      pt_stall,
	input  pad_pkg::pad_in_t          pt,
	output logic                      res_valid,
	input  logic                      res_stall,
	output pad_pkg::pad_out_t         res
);
	import pad_pkg::*;

	logic             adv;
	logic [UPM_W-1:0] upm_q;
	logic [UPM_W-1:0] divisor;

	logic [LAT:1] vld_q;
	logic [LAT:1] mode_q;
	logic [LAT:1] zl_q;

	logic signed [COORD_W:0] dx_c, dy_c, v1x_c, v1y_c, v2x_c, v2y_c;
	logic [COORD_W-1:0]      ax_s1, ay_s1;
	logic signed [COORD_W:0] v1x_s1, v1y_s1, v2x_s1, v2y_s1;
	logic [2*COORD_W-1:0]    sqx_s2, sqy_s2;
	logic [SUM_W-1:0]        sum_s3;
	logic signed [COORD_W:0] r1x, r1y, r2x, r2y;

	pad_sq_t sq_c [SQ_STEPS+1];
	pad_dv_t dv_c [DIV_STEPS+1];
	pad_cr_t c1_c [CORDIC_STEPS+1];
	pad_cr_t c2_c [CORDIC_STEPS+1];
	pad_cr_t c1_s2;
	pad_cr_t c2_s2;

	logic [31:0]          dz;
	logic [SUM_W-1:0]     prod_s23;
	logic [SUM_W-1:0]     rnd;
	logic [ANGLE_W-1:0]   ang_c;
	logic [ANGLE_W-1:0]   ang_s24;
	logic [ANGLE_W-1:0]   ang_dly_q [ANG_DLY:1];
	logic                 res_valid_q;

	assign adv      = !res_valid_q || !res_stall;
	assign pt_stall = !adv;
	assign divisor  = (upm_q == '0) ? UPM_W'(1) : upm_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upm_q <= UPM_RESET;
		end else if (cfg_we) begin
			upm_q <= cfg_wdata;
		end
	end

	// stage 1: differences
	assign dx_c  = (COORD_W+1)'(pt.middle_x) - (COORD_W+1)'(pt.first_x);
	assign dy_c  = (COORD_W+1)'(pt.middle_y) - (COORD_W+1)'(pt.first_y);
	assign v1x_c = -dx_c;
	assign v1y_c = -dy_c;
	assign v2x_c = (COORD_W+1)'(pt.last_x) - (COORD_W+1)'(pt.middle_x);
	assign v2y_c = (COORD_W+1)'(pt.last_y) - (COORD_W+1)'(pt.middle_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-1:1], pt_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_q <= {mode_q[LAT-1:1], pt.mode};
			zl_q   <= {zl_q[LAT-1:1],
				((v1x_c == '0) && (v1y_c == '0)) || ((v2x_c == '0) && (v2y_c == '0))};
			ax_s1  <= COORD_W'(dx_c[COORD_W] ? -dx_c : dx_c);
			ay_s1  <= COORD_W'(dy_c[COORD_W] ? -dy_c : dy_c);
			v1x_s1 <= v1x_c;
			v1y_s1 <= v1y_c;
			v2x_s1 <= v2x_c;
			v2y_s1 <= v2y_c;
		end
	end

	// stage 2: squares, ray pre-rotation into the right half plane
	assign r1x = v1x_s1[COORD_W] ? -v1x_s1 : v1x_s1;
	assign r1y = v1x_s1[COORD_W] ? -v1y_s1 : v1y_s1;
	assign r2x = v2x_s1[COORD_W] ? -v2x_s1 : v2x_s1;
	assign r2y = v2x_s1[COORD_W] ? -v2y_s1 : v2y_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			sqx_s2   <= ax_s1 * ax_s1;
			sqy_s2   <= ay_s1 * ay_s1;
			c1_s2.x  <= XW'(r1x) <<< GUARD_SHIFT;
			c1_s2.y  <= XW'(r1y) <<< GUARD_SHIFT;
			c1_s2.z  <= v1x_s1[COORD_W] ? 32'h8000_0000 : 32'h0;
			c2_s2.x  <= XW'(r2x) <<< GUARD_SHIFT;
			c2_s2.y  <= XW'(r2y) <<< GUARD_SHIFT;
			c2_s2.z  <= v2x_s1[COORD_W] ? 32'h8000_0000 : 32'h0;
		end
	end

	assign c1_c[0] = c1_s2;
	assign c2_c[0] = c2_s2;

	// stage 3: sum of squares
	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s3 <= SUM_W'(sqx_s2) + SUM_W'(sqy_s2);
		end
	end

	assign sq_c[0].rad  = RAD_W'({sum_s3, {(2*FRAC_W){1'b0}}});
	assign sq_c[0].rem  = '0;
	assign sq_c[0].root = '0;

	for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
		pad_sqrt_cell u_cell (.clk(clk), .en(adv), .d(sq_c[i]), .q(sq_c[i+1]));
	end

	assign dv_c[0].num  = sq_c[SQ_STEPS].root;
	assign dv_c[0].rem  = '0;
	assign dv_c[0].quot = '0;

	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
		pad_div_cell u_cell (
			.clk(clk), .en(adv), .divisor(divisor), .d(dv_c[i]), .q(dv_c[i+1])
		);
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
		pad_cordic_cell u_ray1 (
			.clk(clk), .en(adv), .k(5'(i)), .d(c1_c[i]), .q(c1_c[i+1])
		);
		pad_cordic_cell u_ray2 (
			.clk(clk), .en(adv), .k(5'(i)), .d(c2_c[i]), .q(c2_c[i+1])
		);
	end

	// angle scaling to degrees, round half up, wrap a full turn to zero
	assign dz    = c2_c[CORDIC_STEPS].z - c1_c[CORDIC_STEPS].z;
	assign rnd   = prod_s23 + SUM_W'(33'h1_0000_0000 >> 1);
	assign ang_c = rnd[SUM_W-1 -: ANGLE_W];

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s23 <= SUM_W'(dz) * SUM_W'(FULL_TURN);
			ang_s24  <= (zl_q[ANG_STAGE-1] || ang_c >= FULL_TURN) ? '0 : ang_c;
			ang_dly_q[1] <= ang_s24;
			for (int j = 2; j <= ANG_DLY; j++) begin
				ang_dly_q[j] <= ang_dly_q[j-1];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= vld_q[LAT];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res.distance_mm <= mode_q[LAT] ? '0 : dv_c[DIV_STEPS].quot;
			res.angle_deg   <= mode_q[LAT] ? ang_dly_q[ANG_DLY] : '0;
			res.zero_length <= mode_q[LAT] & zl_q[LAT];
		end
	end

	assign res_valid = res_valid_q;

	a_zl_angle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.zero_length |-> res.angle_deg == '0)
		else $error("zero-length ray with nonzero angle");

	a_one_field: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.angle_deg != '0 |-> res.distance_mm == '0)
		else $error("angle and distance both nonzero");

	a_turn: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.angle_deg < FULL_TURN)
		else $error("angle not wrapped below a full turn");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(vld_q))
		else $error("pipeline moved while result stalled");

endmodule
